### design/bdth_pkg.sv
// Shared types and constants for the button debounce and tap/hold block.
`timescale 1ns / 1ps
`default_nettype none
package bdth_pkg;

    localparam int NUM_BTN       = 3;
    localparam int MAX_EV        = 5;
    localparam int CNT_W         = $clog2(MAX_EV + 1);
    localparam int IDX_W         = $clog2(MAX_EV);
    localparam int STAMP_W       = 48;
    localparam int TIME_BITS_DEF = 48;
    localparam int US_PER_MS     = 1000;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DEB_MS_W      = 10;
    localparam int DEB_US_W      = 20;
    localparam int HOLD_US_W     = 26;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_HOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_HOLD = 2'd2;

    localparam logic [DEB_US_W-1:0]  DEBOUNCE_US_RST   = DEB_US_W'(30 * US_PER_MS);
    localparam logic [HOLD_US_W-1:0] MODE_HOLD_US_RST  = HOLD_US_W'(1000 * US_PER_MS);
    localparam logic [HOLD_US_W-1:0] RESET_HOLD_US_RST = HOLD_US_W'(2000 * US_PER_MS);

    typedef enum logic [2:0] {
        EV_MODE_TAP     = 3'd0,
        EV_MODE_PRESSED = 3'd1,
        EV_MODE_HELD    = 3'd2,
        EV_SETLINE_TAP  = 3'd3,
        EV_RESET_TAP    = 3'd4,
        EV_RESET_HELD   = 3'd5,
        EV_RESET_ABORT  = 3'd6
    } event_code_t;

    // Thresholds already scaled to microseconds.
    typedef struct packed {
        logic [DEB_US_W-1:0]  debounce_us;
        logic [HOLD_US_W-1:0] mode_hold_us;
        logic [HOLD_US_W-1:0] reset_hold_us;
    } cfg_t;

    // Events of one sample, in order, slot 0 first.
    typedef struct packed {
        logic [CNT_W-1:0]               count;
        event_code_t [MAX_EV-1:0]       codes;
    } ev_batch_t;

endpackage
`default_nettype wire

### design/bdth_cfg.sv
// Configuration registers, stored pre-scaled from milliseconds to microseconds.
`timescale 1ns / 1ps
`default_nettype none
module bdth_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bdth_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bdth_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bdth_pkg::cfg_t                           cfg
);

    logic [bdth_pkg::DEB_US_W-1:0]  debounce_us_reg;
    logic [bdth_pkg::HOLD_US_W-1:0] mode_hold_us_reg;
    logic [bdth_pkg::HOLD_US_W-1:0] reset_hold_us_reg;

    logic [bdth_pkg::DEB_US_W-1:0]  debounce_us_next;
    logic [bdth_pkg::HOLD_US_W-1:0] hold_us_next;

    // Scaling by a constant; small enough to sit in front of the register.
    assign debounce_us_next = bdth_pkg::DEB_US_W'(cfg_data[bdth_pkg::DEB_MS_W-1:0])
                            * bdth_pkg::DEB_US_W'(bdth_pkg::US_PER_MS);
    assign hold_us_next     = bdth_pkg::HOLD_US_W'(cfg_data)
                            * bdth_pkg::HOLD_US_W'(bdth_pkg::US_PER_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_us_reg   <= bdth_pkg::DEBOUNCE_US_RST;
            mode_hold_us_reg  <= bdth_pkg::MODE_HOLD_US_RST;
            reset_hold_us_reg <= bdth_pkg::RESET_HOLD_US_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdth_pkg::CFG_DEBOUNCE:   debounce_us_reg   <= debounce_us_next;
                bdth_pkg::CFG_MODE_HOLD:  mode_hold_us_reg  <= hold_us_next;
                bdth_pkg::CFG_RESET_HOLD: reset_hold_us_reg <= hold_us_next;
                default: ;
            endcase
        end
    end

    assign cfg.debounce_us   = debounce_us_reg;
    assign cfg.mode_hold_us  = mode_hold_us_reg;
    assign cfg.reset_hold_us = reset_hold_us_reg;

endmodule
`default_nettype wire

### design/bdth_core.sv
// Per-button debounce and tap/hold state with the event logic for one sample.
`timescale 1ns / 1ps
`default_nettype none
module bdth_core #(
    parameter int TIME_BITS = bdth_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic [bdth_pkg::NUM_BTN-1:0]       pins,
    input  wire logic [bdth_pkg::STAMP_W-1:0]       stamp,
    input  wire bdth_pkg::cfg_t                     cfg,
    output bdth_pkg::ev_batch_t                     batch
);

    localparam int NB = bdth_pkg::NUM_BTN;

    logic                 raw_prev_reg    [NB];
    logic                 stable_reg      [NB];
    logic [TIME_BITS-1:0] last_change_reg [NB];
    logic [TIME_BITS-1:0] press_start_reg [NB];
    logic                 hold_done_reg   [NB];

    logic                 raw_next        [NB];
    logic                 stable_next     [NB];
    logic [TIME_BITS-1:0] last_change_next[NB];
    logic [TIME_BITS-1:0] press_start_next[NB];
    logic                 hold_done_next  [NB];

    logic [TIME_BITS-1:0] deb_elapsed     [NB];
    logic [TIME_BITS-1:0] hold_elapsed    [NB];
    logic [TIME_BITS-1:0] hold_thr        [NB];
    logic                 flip            [NB];
    logic                 hold_clear      [NB];

    // Candidate events: two per button, button 1 only ever uses its first.
    logic                  cand_vld [NB][2];
    bdth_pkg::event_code_t cand_code[NB][2];

    logic [63:0]          stamp_wide;
    logic [TIME_BITS-1:0] now;

    assign stamp_wide = 64'(stamp);
    assign now        = stamp_wide[TIME_BITS-1:0];

    assign hold_thr[0] = TIME_BITS'(cfg.mode_hold_us);
    assign hold_thr[1] = '0;
    assign hold_thr[2] = TIME_BITS'(cfg.reset_hold_us);

    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            raw_next[i]         = !pins[i];
            last_change_next[i] = (raw_next[i] != raw_prev_reg[i]) ? now : last_change_reg[i];
            deb_elapsed[i]      = now - last_change_next[i];
            flip[i]             = (deb_elapsed[i] >= TIME_BITS'(cfg.debounce_us))
                               && (raw_next[i] != stable_reg[i]);
            stable_next[i]      = flip[i] ? raw_next[i] : stable_reg[i];
            press_start_next[i] = (flip[i] && raw_next[i]) ? now : press_start_reg[i];
            hold_clear[i]       = flip[i] ? 1'b0 : hold_done_reg[i];
            hold_elapsed[i]     = now - press_start_next[i];

            cand_vld[i][0]  = 1'b0;
            cand_code[i][0] = bdth_pkg::EV_MODE_TAP;
            cand_vld[i][1]  = 1'b0;
            cand_code[i][1] = bdth_pkg::EV_MODE_TAP;
            hold_done_next[i] = hold_clear[i];

            if (flip[i] && raw_next[i])
            begin
                cand_vld[i][0]  = 1'b1;
                cand_code[i][0] = (i == 0) ? bdth_pkg::EV_MODE_PRESSED :
                                  (i == 1) ? bdth_pkg::EV_SETLINE_TAP :
                                             bdth_pkg::EV_RESET_TAP;
            end
            else if (flip[i] && (i != 1) && !hold_done_reg[i])
            begin
                cand_vld[i][0]  = 1'b1;
                cand_code[i][0] = (i == 0) ? bdth_pkg::EV_MODE_TAP : bdth_pkg::EV_RESET_ABORT;
            end

            // The hold check sees the state as this sample leaves it.
            if ((i != 1) && stable_next[i] && !hold_clear[i]
                && (hold_elapsed[i] >= hold_thr[i]))
            begin
                cand_vld[i][1]    = 1'b1;
                cand_code[i][1]   = (i == 0) ? bdth_pkg::EV_MODE_HELD : bdth_pkg::EV_RESET_HELD;
                hold_done_next[i] = 1'b1;
            end
        end
    end

    // Pack the candidates in button order into consecutive slots.
    always_comb
    begin
        logic [bdth_pkg::CNT_W-1:0] cnt;
        cnt = '0;
        for (int s = 0; s < bdth_pkg::MAX_EV; s++)
        begin
            batch.codes[s] = bdth_pkg::EV_MODE_TAP;
        end
        for (int i = 0; i < NB; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (cand_vld[i][k])
                begin
                    batch.codes[cnt[bdth_pkg::IDX_W-1:0]] = cand_code[i][k];
                    cnt = cnt + 1'b1;
                end
            end
        end
        batch.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                raw_prev_reg[i]    <= 1'b0;
                stable_reg[i]      <= 1'b0;
                last_change_reg[i] <= '0;
                press_start_reg[i] <= '0;
                hold_done_reg[i]   <= 1'b0;
            end
        end
        else if (load)
        begin
            for (int i = 0; i < NB; i++)
            begin
                raw_prev_reg[i]    <= raw_next[i];
                stable_reg[i]      <= stable_next[i];
                last_change_reg[i] <= last_change_next[i];
                press_start_reg[i] <= press_start_next[i];
                hold_done_reg[i]   <= hold_done_next[i];
            end
        end
    end

    // A completed hold can only belong to a button that is still pressed.
    a_hold_implies_pressed_0: assert property (@(posedge clk) disable iff (!rst_n)
        hold_done_reg[0] |-> stable_reg[0])
        else $error("mode hold flag set while released");
    a_hold_implies_pressed_2: assert property (@(posedge clk) disable iff (!rst_n)
        hold_done_reg[2] |-> stable_reg[2])
        else $error("reset hold flag set while released");
    // The setline button has no hold behavior.
    a_setline_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_done_reg[1])
        else $error("setline hold flag set");

endmodule
`default_nettype wire

### design/bdth_evq.sv
// Event buffer that delivers the events of one sample, one per transaction.
`timescale 1ns / 1ps
`default_nettype none
module bdth_evq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire bdth_pkg::ev_batch_t  batch,
    output logic                      can_load,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                event_code,
    output logic                      last_of_sample
);

    localparam int ME = bdth_pkg::MAX_EV;

    bdth_pkg::event_code_t      codes_reg  [ME];
    bdth_pkg::event_code_t      codes_next [ME];
    logic [bdth_pkg::CNT_W-1:0] count_reg;
    logic [bdth_pkg::CNT_W-1:0] count_next;
    logic                       take;

    assign out_valid      = (count_reg != '0);
    assign take           = out_valid && out_ready;
    assign can_load       = (count_reg == '0)
                         || ((count_reg == bdth_pkg::CNT_W'(1)) && out_ready);
    assign event_code     = codes_reg[0];
    assign last_of_sample = (count_reg == bdth_pkg::CNT_W'(1));

    always_comb
    begin
        for (int s = 0; s < ME; s++)
        begin
            codes_next[s] = codes_reg[s];
        end
        count_next = count_reg;
        if (load)
        begin
            for (int s = 0; s < ME; s++)
            begin
                codes_next[s] = batch.codes[s];
            end
            count_next = batch.count;
        end
        else if (take)
        begin
            for (int s = 0; s < ME - 1; s++)
            begin
                codes_next[s] = codes_reg[s + 1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ME; s++)
        begin
            codes_reg[s] <= codes_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdth_pkg::CNT_W'(ME))
        else $error("event buffer overfilled");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == '0) || (count_reg == bdth_pkg::CNT_W'(1) && take))
        else $error("event buffer loaded while events still pending");
    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !load) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("event buffer lost or repeated an event");

endmodule
`default_nettype wire

### design/button_debounce_tap_hold_top.sv
// Top level of the three-button debouncer with tap and long-press events.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction is one poll sample: three active-low pin levels
// (bit 0 mode, bit 1 setline, bit 2 reset) and a free-running microsecond
// timestamp. The sample is captured in an input register; when the event
// buffer can take its events, the per-button debounce and hold logic
// evaluates it in a single pass, updates the button state and loads the
// resulting events, in button order, into the event buffer. Events leave
// one per output transaction, and last_of_sample marks the final event of
// a sample. A sample that causes no event produces no output at all. A
// sample with several events holds the event buffer until all of them are
// taken, as the output port carries one event at a time and out_ready can
// stall it; the next sample is evaluated in the cycle the last event of the
// previous one is taken. The first event of a sample is presented once the
// sample has passed the input register and been loaded into the event buffer.
// Thresholds are held in microseconds, scaled at configuration write time,
// and all elapsed times are taken modulo 2^TIME_BITS. Configuration must
// only be written while the block is idle.
module button_debounce_tap_hold_top #(
    parameter int TIME_BITS = bdth_pkg::TIME_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [2:0]                          pin_levels,
    input  wire logic [bdth_pkg::STAMP_W-1:0]        sample_time_us,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [2:0]                               event_code,
    output logic                                     last_of_sample,
    input  wire logic                                cfg_we,
    input  wire logic [bdth_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bdth_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bdth_pkg::cfg_t      cfg;
    bdth_pkg::ev_batch_t batch;

    // Input register holding one sample until the core takes it.
    logic                           in_valid_reg;
    logic [2:0]                     pins_reg;
    logic [bdth_pkg::STAMP_W-1:0]   stamp_reg;

    logic can_load;
    logic consume;

    // The core consumes the held sample whenever the event buffer is free
    // or frees up in this cycle.
    assign consume  = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pins_reg  <= pin_levels;
            stamp_reg <= sample_time_us;
        end
    end

    bdth_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdth_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (consume),
        .pins  (pins_reg),
        .stamp (stamp_reg),
        .cfg   (cfg),
        .batch (batch)
    );

    bdth_evq u_evq (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (consume),
        .batch          (batch),
        .can_load       (can_load),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_code     (event_code),
        .last_of_sample (last_of_sample)
    );

endmodule
`default_nettype wire
